>>> design/rvsec_pkg.sv
package rvsec_pkg;

  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned REG_AW = $clog2(NUM_REGS);

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_DATA_BASE = 3'd0;
  localparam logic [15:0] DATA_BASE_RESET = 16'h0400;

  typedef struct packed {
    logic [31:0]       npc;
    logic              ill;
    logic              wr;
    logic [REG_AW-1:0] rd;
    logic [31:0]       val;
    logic              mem_ld;
    logic              mem_st;
    logic [31:0]       off;
    logic [2:0]        f3;
    logic              ext;
    logic              ext_st;
    logic [31:0]       ext_addr;
    logic [31:0]       ext_data;
    logic [1:0]        ext_sz;
  } ex_t;

endpackage

>>> design/rvsec_instr_if.sv
interface rvsec_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

>>> design/rvsec_result_if.sv
interface rvsec_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        illegal_instr;
  logic        reg_write_en;
  logic [4:0]  reg_write_index;
  logic [31:0] reg_write_value;
  logic        ext_access;
  logic        ext_is_store;
  logic [31:0] ext_address;
  logic [31:0] ext_store_data;
  logic [1:0]  ext_size;

  modport source (
    output valid, output next_pc, output illegal_instr, output reg_write_en,
    output reg_write_index, output reg_write_value, output ext_access,
    output ext_is_store, output ext_address, output ext_store_data, output ext_size,
    input ready
  );
  modport sink (
    input valid, input next_pc, input illegal_instr, input reg_write_en,
    input reg_write_index, input reg_write_value, input ext_access,
    input ext_is_store, input ext_address, input ext_store_data, input ext_size,
    output ready
  );
endinterface

>>> design/rvsec_ram.sv
module rvsec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rvsec_exec.sv
module rvsec_exec #(
  parameter int unsigned DATA_BYTES = 1024
) (
  input  logic [31:0]        instr_i,
  input  logic [31:0]        pc_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  input  logic [15:0]        base_i,
  output rvsec_pkg::ex_t     ex_o
);

  localparam logic [31:0] WIN = 32'(DATA_BYTES);

  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs2, shamt;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, op2, sum, diff, ls_addr, off, size, pc4;
  logic        slt, sltu, in_win, b_eq, b_lt, b_ltu, take;

  always_comb begin
    opc   = instr_i[6:0];
    rd    = instr_i[11:7];
    f3    = instr_i[14:12];
    rs2   = instr_i[24:20];
    f7    = instr_i[31:25];
    imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
    imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
    imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
    imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20], instr_i[30:21],
             1'b0};
    op2   = (opc == rvsec_pkg::OPC_OP) ? b_i : imm_i;
    shamt = (opc == rvsec_pkg::OPC_OP) ? b_i[4:0] : rs2;
    sum   = a_i + op2;
    diff  = a_i - b_i;
    slt   = $signed(a_i) < $signed(op2);
    sltu  = a_i < op2;
    b_eq  = a_i == b_i;
    b_lt  = $signed(a_i) < $signed(b_i);
    b_ltu = a_i < b_i;
    pc4   = pc_i + 32'd4;
    ls_addr = a_i + ((opc == rvsec_pkg::OPC_STORE) ? imm_s : imm_i);
    off   = ls_addr - {16'd0, base_i};
    case (f3[1:0])
      rvsec_pkg::SZ_BYTE: size = 32'd1;
      rvsec_pkg::SZ_HALF: size = 32'd2;
      default:            size = 32'd4;
    endcase
    in_win = off <= (WIN - size);
    take   = 1'b0;

    ex_o          = '0;
    ex_o.npc      = pc4;
    ex_o.rd       = rd;
    ex_o.off      = off;
    ex_o.f3       = f3;

    case (opc)
      rvsec_pkg::OPC_OP, rvsec_pkg::OPC_OP_IMM: begin
        ex_o.wr = 1'b1;
        case (f3)
          rvsec_pkg::F3_ADD: begin
            if (opc == rvsec_pkg::OPC_OP_IMM || f7 == rvsec_pkg::F7_BASE) ex_o.val = sum;
            else if (f7 == rvsec_pkg::F7_ALT) ex_o.val = diff;
            else ex_o.ill = 1'b1;
          end
          rvsec_pkg::F3_SLL: begin
            if (opc == rvsec_pkg::OPC_OP || f7 == rvsec_pkg::F7_BASE) ex_o.val = a_i << shamt;
            else ex_o.ill = 1'b1;
          end
          rvsec_pkg::F3_SLT:  ex_o.val = {31'd0, slt};
          rvsec_pkg::F3_SLTU: ex_o.val = {31'd0, sltu};
          rvsec_pkg::F3_XOR:  ex_o.val = a_i ^ op2;
          rvsec_pkg::F3_SR: begin
            if (f7 == rvsec_pkg::F7_BASE) ex_o.val = a_i >> shamt;
            else if (f7 == rvsec_pkg::F7_ALT) ex_o.val = 32'($signed(a_i) >>> shamt);
            else ex_o.ill = 1'b1;
          end
          rvsec_pkg::F3_OR:   ex_o.val = a_i | op2;
          default:            ex_o.val = a_i & op2;
        endcase
      end
      rvsec_pkg::OPC_LUI: begin
        ex_o.wr  = 1'b1;
        ex_o.val = {instr_i[31:12], 12'd0};
      end
      rvsec_pkg::OPC_LOAD: begin
        if (f3 == rvsec_pkg::F3_SLTU || f3 > rvsec_pkg::F3_LHU) begin
          ex_o.ill = 1'b1;
        end else begin
          ex_o.wr = 1'b1;
          if (in_win) begin
            ex_o.mem_ld = 1'b1;
          end else begin
            ex_o.ext      = 1'b1;
            ex_o.ext_addr = ls_addr;
            ex_o.ext_sz   = f3[1:0];
          end
        end
      end
      rvsec_pkg::OPC_STORE: begin
        if (f3 > rvsec_pkg::F3_LW) begin
          ex_o.ill = 1'b1;
        end else if (in_win) begin
          ex_o.mem_st = 1'b1;
        end else begin
          ex_o.ext      = 1'b1;
          ex_o.ext_st   = 1'b1;
          ex_o.ext_addr = ls_addr;
          ex_o.ext_data = b_i;
          ex_o.ext_sz   = f3[1:0];
        end
      end
      rvsec_pkg::OPC_BRANCH: begin
        case (f3)
          rvsec_pkg::F3_BEQ:  take = b_eq;
          rvsec_pkg::F3_BNE:  take = !b_eq;
          rvsec_pkg::F3_BLT:  take = b_lt;
          rvsec_pkg::F3_BGE:  take = !b_lt;
          rvsec_pkg::F3_BLTU: take = b_ltu;
          rvsec_pkg::F3_BGEU: take = !b_ltu;
          default:            ex_o.ill = 1'b1;
        endcase
        if (take) ex_o.npc = pc_i + imm_b;
      end
      rvsec_pkg::OPC_JAL: begin
        ex_o.wr  = 1'b1;
        ex_o.val = pc4;
        ex_o.npc = pc_i + imm_j;
      end
      rvsec_pkg::OPC_JALR: begin
        if (f3 != rvsec_pkg::F3_ADD) begin
          ex_o.ill = 1'b1;
        end else begin
          ex_o.wr  = 1'b1;
          ex_o.val = pc4;
          ex_o.npc = {ls_addr[31:1], 1'b0};
        end
      end
      default: ex_o.ill = 1'b1;
    endcase

    if (ex_o.ill) begin
      ex_o.npc      = pc_i;
      ex_o.wr       = 1'b0;
      ex_o.mem_ld   = 1'b0;
      ex_o.mem_st   = 1'b0;
      ex_o.ext      = 1'b0;
      ex_o.ext_st   = 1'b0;
      ex_o.ext_addr = '0;
      ex_o.ext_data = '0;
      ex_o.ext_sz   = '0;
    end
    if (rd == '0) ex_o.wr = 1'b0;
    if (!ex_o.wr) begin
      ex_o.val    = '0;
      ex_o.rd     = '0;
      ex_o.mem_ld = 1'b0;
    end
  end

endmodule

>>> design/rv32i_subset_execute_core.sv
// RV32I subset execute core.
// in_i carries one instruction word per request, the word at the current pc.
// res_o returns one result per instruction: next pc, register write, illegal
// flag and any load/store that falls outside the internal data window.
// The APB port holds data_base_address at offset 0; write it only while idle.
// A result passes the execute (b_*), memory (c_*) and output (out_*) registers in turn.
// Throughput: one instruction per cycle while res_o does not stall. Register
// file reads happen at the accept edge, data memory (four byte banks) is read
// and written at the execute edge, the register file is written as a result
// enters the output register; bypass paths cover instructions still in flight.
// A stall on res_o freezes the whole pipe and drops in_i.ready.
// Reset clears pc and register file valid bits and loads the config register
// with DATA_BASE_RESET, then a clearing pass zeroes the data memory, one row
// per cycle, with in_i.ready low. APB writes are taken during the pass.
module rv32i_subset_execute_core #(
  parameter int unsigned DATA_BYTES = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rvsec_instr_if.sink                      in_i,
  rvsec_result_if.source                   res_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rvsec_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned ROWS = DATA_BYTES / 4;
  localparam int unsigned ROWW = $clog2(ROWS);
  localparam int unsigned AW   = $clog2(DATA_BYTES);
  localparam int unsigned RAW  = rvsec_pkg::REG_AW;

  logic adv;
  logic [15:0] base_q;
  logic clr_busy_q;
  logic [ROWW-1:0] clr_cnt_q;

  logic [rvsec_pkg::NUM_REGS-1:0] rv_q;
  logic [31:0] pc_q;

  logic        b_valid_q;
  logic [31:0] b_instr_q;
  logic        rs1_ok_q, rs2_ok_q, byp1_v_q, byp2_v_q;
  logic [31:0] byp1_val_q, byp2_val_q;
  logic [31:0] rf1_rdata, rf2_rdata;

  logic           c_valid_q, c_wr_q, c_ld_q;
  logic [RAW-1:0] c_rd_q;
  logic [31:0]    c_val_q, c_npc_q, c_ext_addr_q, c_ext_data_q;
  logic [2:0]     c_f3_q;
  logic [1:0]     c_lo_q, c_ext_sz_q;
  logic           c_ill_q, c_ext_q, c_ext_st_q;
  logic [31:0]    c_fin;
  logic           c_we;

  logic        out_valid_q;
  logic        out_ill_q, out_wr_q, out_ext_q, out_ext_st_q;
  logic [4:0]  out_rd_q;
  logic [31:0] out_val_q, out_npc_q, out_ext_addr_q, out_ext_data_q;
  logic [1:0]  out_ext_sz_q;

  logic [RAW-1:0] b_rs1, b_rs2, in_rs1, in_rs2;
  logic [31:0] op_a, op_b;
  rvsec_pkg::ex_t ex;

  logic [7:0]      bk_rdata [4];
  logic [7:0]      bk_wdata [4];
  logic [ROWW-1:0] bk_addr [4];
  logic [3:0]      bk_we;
  logic [7:0]      ld_byte [4];
  logic [31:0]     ld_val;

  assign adv   = !out_valid_q || res_o.ready;
  assign in_i.ready = adv && !clr_busy_q;
  assign pready = 1'b1;
  assign prdata = (paddr == rvsec_pkg::REG_DATA_BASE) ? {16'd0, base_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= rvsec_pkg::DATA_BASE_RESET;
    end else if (psel && penable && pwrite && paddr == rvsec_pkg::REG_DATA_BASE) begin
      base_q <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == ROWW'(ROWS - 1)) clr_busy_q <= 1'b0;
    end
  end

  // register file: two read copies, valid bits stand in for reset
  assign in_rs1 = in_i.instr_word[19:15];
  assign in_rs2 = in_i.instr_word[24:20];
  assign c_we   = adv && c_valid_q && c_wr_q;

  rvsec_ram #(.WIDTH(32), .DEPTH(rvsec_pkg::NUM_REGS)) u_rf1 (
    .clk_i(clk_i), .we_i(c_we), .waddr_i(c_rd_q), .wdata_i(c_fin),
    .re_i(adv), .raddr_i(in_rs1), .rdata_o(rf1_rdata)
  );
  rvsec_ram #(.WIDTH(32), .DEPTH(rvsec_pkg::NUM_REGS)) u_rf2 (
    .clk_i(clk_i), .we_i(c_we), .waddr_i(c_rd_q), .wdata_i(c_fin),
    .re_i(adv), .raddr_i(in_rs2), .rdata_o(rf2_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q      <= '0;
      pc_q      <= '0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (c_we) rv_q[c_rd_q] <= 1'b1;
      if (b_valid_q) pc_q <= ex.npc;
      b_valid_q   <= in_i.valid && in_i.ready;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_instr_q  <= in_i.instr_word;
      rs1_ok_q   <= rv_q[in_rs1];
      rs2_ok_q   <= rv_q[in_rs2];
      byp1_v_q   <= c_we && c_rd_q == in_rs1;
      byp2_v_q   <= c_we && c_rd_q == in_rs2;
      byp1_val_q <= c_fin;
      byp2_val_q <= c_fin;
    end
  end

  // execute stage operands
  assign b_rs1 = b_instr_q[19:15];
  assign b_rs2 = b_instr_q[24:20];

  always_comb begin
    if (b_rs1 == '0) op_a = '0;
    else if (c_valid_q && c_wr_q && c_rd_q == b_rs1) op_a = c_fin;
    else if (byp1_v_q) op_a = byp1_val_q;
    else if (rs1_ok_q) op_a = rf1_rdata;
    else op_a = '0;
    if (b_rs2 == '0) op_b = '0;
    else if (c_valid_q && c_wr_q && c_rd_q == b_rs2) op_b = c_fin;
    else if (byp2_v_q) op_b = byp2_val_q;
    else if (rs2_ok_q) op_b = rf2_rdata;
    else op_b = '0;
  end

  rvsec_exec #(.DATA_BYTES(DATA_BYTES)) u_exec (
    .instr_i(b_instr_q), .pc_i(pc_q), .a_i(op_a), .b_i(op_b), .base_i(base_q), .ex_o(ex)
  );

  // data memory: byte k of a bank row holds window offsets with offset mod 4 == k
  always_comb begin
    logic [1:0]  idx;
    logic        act;
    logic [AW-1:0] pos;
    for (int k = 0; k < 4; k++) begin
      idx = 2'(k) - ex.off[1:0];
      case (ex.f3[1:0])
        rvsec_pkg::SZ_BYTE: act = idx == 2'd0;
        rvsec_pkg::SZ_HALF: act = !idx[1];
        default:            act = 1'b1;
      endcase
      pos = ex.off[AW-1:0] + AW'(idx);
      if (clr_busy_q) begin
        bk_we[k]    = 1'b1;
        bk_addr[k]  = clr_cnt_q;
        bk_wdata[k] = '0;
      end else begin
        bk_we[k]    = adv && b_valid_q && ex.mem_st && act;
        bk_addr[k]  = pos[AW-1:2];
        bk_wdata[k] = op_b[8*idx +: 8];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    rvsec_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk_i(clk_i), .we_i(bk_we[g]), .waddr_i(bk_addr[g]), .wdata_i(bk_wdata[g]),
      .re_i(adv), .raddr_i(bk_addr[g]), .rdata_o(bk_rdata[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_wr_q       <= ex.wr;
      c_ld_q       <= ex.mem_ld;
      c_rd_q       <= ex.rd;
      c_val_q      <= ex.val;
      c_npc_q      <= ex.npc;
      c_f3_q       <= ex.f3;
      c_lo_q       <= ex.off[1:0];
      c_ill_q      <= ex.ill;
      c_ext_q      <= ex.ext;
      c_ext_st_q   <= ex.ext_st;
      c_ext_addr_q <= ex.ext_addr;
      c_ext_data_q <= ex.ext_data;
      c_ext_sz_q   <= ex.ext_sz;
    end
  end

  // load alignment
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_byte[i] = bk_rdata[2'(c_lo_q + 2'(i))];
    end
    case (c_f3_q)
      rvsec_pkg::F3_LB:  ld_val = {{24{ld_byte[0][7]}}, ld_byte[0]};
      rvsec_pkg::F3_LH:  ld_val = {{16{ld_byte[1][7]}}, ld_byte[1], ld_byte[0]};
      rvsec_pkg::F3_LBU: ld_val = {24'd0, ld_byte[0]};
      rvsec_pkg::F3_LHU: ld_val = {16'd0, ld_byte[1], ld_byte[0]};
      default:           ld_val = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
    endcase
    c_fin = c_ld_q ? ld_val : c_val_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_npc_q      <= c_npc_q;
      out_ill_q      <= c_ill_q;
      out_wr_q       <= c_wr_q;
      out_rd_q       <= c_rd_q;
      out_val_q      <= c_fin;
      out_ext_q      <= c_ext_q;
      out_ext_st_q   <= c_ext_st_q;
      out_ext_addr_q <= c_ext_addr_q;
      out_ext_data_q <= c_ext_data_q;
      out_ext_sz_q   <= c_ext_sz_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.next_pc         = out_npc_q;
  assign res_o.illegal_instr   = out_ill_q;
  assign res_o.reg_write_en    = out_wr_q;
  assign res_o.reg_write_index = out_rd_q;
  assign res_o.reg_write_value = out_val_q;
  assign res_o.ext_access      = out_ext_q;
  assign res_o.ext_is_store    = out_ext_st_q;
  assign res_o.ext_address     = out_ext_addr_q;
  assign res_o.ext_store_data  = out_ext_data_q;
  assign res_o.ext_size        = out_ext_sz_q;

endmodule

>>> design/rvsec_checker.sv
module rvsec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        illegal_i,
  input logic        wen_i,
  input logic [4:0]  widx_i,
  input logic [31:0] wval_i,
  input logic        ext_i,
  input logic        ext_st_i,
  input logic [31:0] ext_addr_i,
  input logic [31:0] ext_data_i,
  input logic [1:0]  ext_sz_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("request taken during memory clear");

  a_ill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && illegal_i |-> !wen_i && !ext_i)
    else $error("illegal instruction has side effects");

  a_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !wen_i |-> widx_i == 5'd0 && wval_i == 32'd0)
    else $error("write fields set without write");

  a_noext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ext_i |-> !ext_st_i && ext_addr_i == 32'd0 && ext_data_i == 32'd0
      && ext_sz_i == 2'd0)
    else $error("external fields set without external access");

endmodule

bind rv32i_subset_execute_core rvsec_checker u_rvsec_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_ready_i(in_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .illegal_i(res_o.illegal_instr),
  .wen_i(res_o.reg_write_en),
  .widx_i(res_o.reg_write_index),
  .wval_i(res_o.reg_write_value),
  .ext_i(res_o.ext_access),
  .ext_st_i(res_o.ext_is_store),
  .ext_addr_i(res_o.ext_address),
  .ext_data_i(res_o.ext_store_data),
  .ext_sz_i(res_o.ext_size)
);

>>> tb/tb.sv
module tb;

  localparam int unsigned DMEM_BYTES = 1024;
  localparam logic [2:0] F3_LOAD_BAD = 3'd3;
  localparam logic [2:0] F3_STORE_BAD = 3'd3;
  localparam logic [2:0] F3_BR_BAD = 3'd2;
  localparam logic [6:0] OPC_BAD = 7'h7F;
  localparam logic [6:0] F7_ODD = 7'h01;

  typedef struct packed {
    logic [31:0] npc;
    logic        ill;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        ext;
    logic        ext_st;
    logic [31:0] ext_addr;
    logic [31:0] ext_data;
    logic [1:0]  ext_sz;
  } retire_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rvsec_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rvsec_instr_if  instr_ch ();
  rvsec_result_if res_ch ();

  rv32i_subset_execute_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (instr_ch.sink),
    .res_o   (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow architectural state
  logic [31:0] gpr [32];
  logic [31:0] cur_pc;
  logic [7:0]  dmem [DMEM_BYTES];
  logic [31:0] win_base;

  retire_t expected_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit failed = 1'b0;

  function automatic logic [31:0] sext(logic [31:0] v, int unsigned bits);
    logic [31:0] m;
    m = 32'h1 << (bits - 1);
    return ((v & ((32'h1 << bits) - 1)) ^ m) - m;
  endfunction

  function automatic bit in_win(logic [31:0] addr, logic [31:0] size);
    logic [31:0] off;
    off = addr - win_base;
    return off <= DMEM_BYTES - size;
  endfunction

  function automatic retire_t execute_instr(logic [31:0] w);
    retire_t r;
    logic [6:0] opc;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [31:0] a, b, imm_i, imm, addr, npc, val, size, off;
    bit ill, wr, take;
    opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20];
    f7 = w[31:25];
    a = gpr[rs1]; b = gpr[rs2];
    imm_i = sext(w >> 20, 12);
    npc = cur_pc + 4; val = '0; ill = 0; wr = 0; take = 0;
    r = '0;
    case (opc)
      rvsec_pkg::OPC_OP: begin
        wr = 1;
        case (f3)
          rvsec_pkg::F3_ADD: if (f7 == rvsec_pkg::F7_BASE) val = a + b;
                  else if (f7 == rvsec_pkg::F7_ALT) val = a - b; else ill = 1;
          rvsec_pkg::F3_SLL: val = a << b[4:0];
          rvsec_pkg::F3_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          rvsec_pkg::F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
          rvsec_pkg::F3_XOR: val = a ^ b;
          rvsec_pkg::F3_SR: if (f7 == rvsec_pkg::F7_BASE) val = a >> b[4:0];
                 else if (f7 == rvsec_pkg::F7_ALT) val = $signed(a) >>> b[4:0];
                 else ill = 1;
          rvsec_pkg::F3_OR: val = a | b;
          default: val = a & b;
        endcase
      end
      rvsec_pkg::OPC_OP_IMM: begin
        wr = 1;
        case (f3)
          rvsec_pkg::F3_ADD: val = a + imm_i;
          rvsec_pkg::F3_SLL: if (f7 == rvsec_pkg::F7_BASE) val = a << rs2; else ill = 1;
          rvsec_pkg::F3_SLT: val = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
          rvsec_pkg::F3_SLTU: val = (a < imm_i) ? 32'd1 : 32'd0;
          rvsec_pkg::F3_XOR: val = a ^ imm_i;
          rvsec_pkg::F3_SR: if (f7 == rvsec_pkg::F7_BASE) val = a >> rs2;
                 else if (f7 == rvsec_pkg::F7_ALT) val = $signed(a) >>> rs2;
                 else ill = 1;
          rvsec_pkg::F3_OR: val = a | imm_i;
          default: val = a & imm_i;
        endcase
      end
      rvsec_pkg::OPC_LUI: begin
        wr = 1;
        val = w & 32'hFFFFF000;
      end
      rvsec_pkg::OPC_LOAD: begin
        if (f3 == F3_LOAD_BAD || f3 > rvsec_pkg::F3_LHU) begin
          ill = 1;
        end else begin
          size = 32'h1 << f3[1:0];
          addr = a + imm_i;
          wr = 1;
          if (in_win(addr, size)) begin
            off = addr - win_base;
            for (int i = 0; i < 4; i++)
              if (i < size) val[8*i +: 8] = dmem[(off + i) % DMEM_BYTES];
            if (f3 == rvsec_pkg::F3_LB) val = sext(val, 8);
            else if (f3 == rvsec_pkg::F3_LH) val = sext(val, 16);
          end else begin
            r.ext = 1; r.ext_addr = addr; r.ext_sz = f3[1:0];
          end
        end
      end
      rvsec_pkg::OPC_STORE: begin
        if (f3 > rvsec_pkg::F3_LW) begin
          ill = 1;
        end else begin
          size = 32'h1 << f3;
          imm = sext({f7, rd}, 12);
          addr = a + imm;
          if (in_win(addr, size)) begin
            off = addr - win_base;
            for (int i = 0; i < 4; i++)
              if (i < size) dmem[(off + i) % DMEM_BYTES] = b[8*i +: 8];
          end else begin
            r.ext = 1; r.ext_st = 1; r.ext_addr = addr; r.ext_data = b;
            r.ext_sz = f3[1:0];
          end
        end
      end
      rvsec_pkg::OPC_BRANCH: begin
        imm = sext({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
        case (f3)
          rvsec_pkg::F3_BEQ: take = (a == b);
          rvsec_pkg::F3_BNE: take = (a != b);
          rvsec_pkg::F3_BLT: take = $signed(a) < $signed(b);
          rvsec_pkg::F3_BGE: take = $signed(a) >= $signed(b);
          rvsec_pkg::F3_BLTU: take = a < b;
          rvsec_pkg::F3_BGEU: take = a >= b;
          default: ill = 1;
        endcase
        if (take) npc = cur_pc + imm;
      end
      rvsec_pkg::OPC_JAL: begin
        imm = sext({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
        wr = 1;
        val = cur_pc + 4;
        npc = cur_pc + imm;
      end
      rvsec_pkg::OPC_JALR: begin
        if (f3 != 3'd0) begin
          ill = 1;
        end else begin
          wr = 1;
          val = cur_pc + 4;
          npc = (a + imm_i) & ~32'h1;
        end
      end
      default: ill = 1;
    endcase
    if (ill) begin
      npc = cur_pc; wr = 0; r = '0;
    end
    if (wr && rd == 5'd0) wr = 0;
    if (wr) gpr[rd] = val;
    else val = '0;
    cur_pc = npc;
    r.npc = npc; r.ill = ill; r.wr = wr; r.rd = wr ? rd : 5'd0; r.val = val;
    return r;
  endfunction

  task automatic issue(logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      instr_ch.valid = 1'b0;
      instr_ch.instr_word = $urandom;
      @(negedge clk_i);
    end
    instr_ch.valid = 1'b1;
    instr_ch.instr_word = w;
    do @(posedge clk_i); while (!instr_ch.ready);
    expected_q.push_back(execute_instr(w));
    @(negedge clk_i);
    instr_ch.valid = 1'b0;
  endtask

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvsec_pkg::OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvsec_pkg::OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvsec_pkg::OPC_JAL};
  endfunction

  task automatic load_reg(logic [4:0] rd, logic [31:0] v);
    logic [31:0] hi;
    hi = (v + 32'h800) & 32'hFFFFF000;
    issue({hi[31:12], rd, rvsec_pkg::OPC_LUI});
    issue(enc_i(v[11:0], rd, rvsec_pkg::F3_ADD, rd, rvsec_pkg::OPC_OP_IMM));
  endtask

  // memory access to a chosen address through a random base register and offset
  task automatic mem_op(bit is_store, logic [2:0] f3, logic [31:0] addr);
    logic [4:0] rs1, rs2, rd;
    logic [11:0] imm;
    rs1 = $urandom_range(1, 31);
    rs2 = $urandom_range(0, 31);
    rd = $urandom_range(0, 31);
    imm = $urandom;
    if (is_store && rs2 != rs1 && rs2 != 0) load_reg(rs2, $urandom);
    load_reg(rs1, addr - sext({20'h0, imm}, 12));
    if (is_store) issue(enc_s(imm, rs2, rs1, f3));
    else issue(enc_i(imm, rs1, f3, rd, rvsec_pkg::OPC_LOAD));
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [15:0] v);
    drain();
    psel = 1'b1; pwrite = 1'b1; paddr = rvsec_pkg::REG_DATA_BASE; pwdata = {16'h0, v};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    win_base = {16'h0, v};
    psel = 1'b1; paddr = rvsec_pkg::REG_DATA_BASE;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== v) begin
      $display("%0t base readback: expected %h actual %h", $time, v, prdata[15:0]);
      failed = 1'b1;
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s: expected %h actual %h", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    retire_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual pc %h", $time, res_ch.next_pc);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        check_field("next_pc", e.npc, res_ch.next_pc);
        check_field("illegal_instr", e.ill, res_ch.illegal_instr);
        check_field("reg_write_en", e.wr, res_ch.reg_write_en);
        check_field("reg_write_index", e.rd, res_ch.reg_write_index);
        check_field("reg_write_value", e.val, res_ch.reg_write_value);
        check_field("ext_access", e.ext, res_ch.ext_access);
        check_field("ext_is_store", e.ext_st, res_ch.ext_is_store);
        check_field("ext_address", e.ext_addr, res_ch.ext_address);
        check_field("ext_store_data", e.ext_data, res_ch.ext_store_data);
        check_field("ext_size", e.ext_sz, res_ch.ext_size);
      end
    end
  end

  always @(negedge clk_i) res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic test_alu_extremes();
    load_reg(5'd2, 32'h8000_0000);
    load_reg(5'd3, 32'hFFFF_FFFF);
    load_reg(5'd4, 32'h0000_0021);
    issue(enc_r(rvsec_pkg::F7_ALT, 5'd3, 5'd2, rvsec_pkg::F3_ADD, 5'd5, rvsec_pkg::OPC_OP));
    issue(enc_r(rvsec_pkg::F7_ALT, 5'd4, 5'd2, rvsec_pkg::F3_SR, 5'd6, rvsec_pkg::OPC_OP));
    issue(enc_r(rvsec_pkg::F7_BASE, 5'd4, 5'd3, rvsec_pkg::F3_SLL, 5'd7, rvsec_pkg::OPC_OP));
    issue(enc_r(F7_ODD, 5'd3, 5'd2, rvsec_pkg::F3_XOR, 5'd8, rvsec_pkg::OPC_OP));
    issue(enc_r(F7_ODD, 5'd3, 5'd2, rvsec_pkg::F3_ADD, 5'd8, rvsec_pkg::OPC_OP));
    issue(enc_r(rvsec_pkg::F7_BASE, 5'd3, 5'd2, rvsec_pkg::F3_SLT, 5'd9, rvsec_pkg::OPC_OP));
    issue(enc_r(rvsec_pkg::F7_BASE, 5'd3, 5'd2, rvsec_pkg::F3_SLTU, 5'd9, rvsec_pkg::OPC_OP));
    issue(enc_i(12'hFFF, 5'd0, rvsec_pkg::F3_SLTU, 5'd10, rvsec_pkg::OPC_OP_IMM));
    issue(enc_i(12'h800, 5'd2, rvsec_pkg::F3_SLT, 5'd10, rvsec_pkg::OPC_OP_IMM));
    issue(enc_i(12'h7FF, 5'd3, rvsec_pkg::F3_AND, 5'd0, rvsec_pkg::OPC_OP_IMM));
    issue(enc_i({rvsec_pkg::F7_ALT, 5'd31}, 5'd2, rvsec_pkg::F3_SR, 5'd11,
                rvsec_pkg::OPC_OP_IMM));
    issue(enc_i({rvsec_pkg::F7_ALT, 5'd1}, 5'd2, rvsec_pkg::F3_SLL, 5'd11,
                rvsec_pkg::OPC_OP_IMM));
  endtask

  task automatic test_mem_edges();
    mem_op(1'b1, rvsec_pkg::F3_LW, win_base + DMEM_BYTES - 4);
    mem_op(1'b0, rvsec_pkg::F3_LB, win_base + DMEM_BYTES - 1);
    mem_op(1'b0, rvsec_pkg::F3_LW, win_base + DMEM_BYTES - 3);
    mem_op(1'b1, rvsec_pkg::F3_LH, win_base - 1);
    mem_op(1'b0, rvsec_pkg::F3_LHU, win_base + DMEM_BYTES - 2);
    issue(enc_i(12'h0, 5'd0, F3_LOAD_BAD, 5'd1, rvsec_pkg::OPC_LOAD));
    issue(enc_s(12'h0, 5'd1, 5'd0, F3_STORE_BAD));
  endtask

  task automatic test_control_flow();
    issue(enc_b(13'h1FF8, 5'd0, 5'd0, rvsec_pkg::F3_BEQ));
    issue(enc_b(13'h0FFE, 5'd3, 5'd2, rvsec_pkg::F3_BLT));
    issue(enc_b(13'h0008, 5'd3, 5'd2, F3_BR_BAD));
    issue(enc_j(21'h100000, 5'd1));
    issue(enc_i(12'h7FF, 5'd3, 3'd0, 5'd1, rvsec_pkg::OPC_JALR));
    issue(enc_i(12'h0, 5'd1, 3'd1, 5'd1, rvsec_pkg::OPC_JALR));
    issue({25'h1FFFFFF, OPC_BAD});
  endtask

  task automatic test_random(int unsigned n);
    int unsigned start, pick;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [31:0] w;
    start = expected_q.size();
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      f3 = $urandom;
      w = $urandom;
      f7 = ($urandom_range(9) == 0) ? w[31:25]
         : ($urandom_range(1) ? rvsec_pkg::F7_ALT : rvsec_pkg::F7_BASE);
      if (pick < 30) begin
        issue(enc_r(f7, w[24:20], w[19:15], f3, w[11:7], rvsec_pkg::OPC_OP));
      end else if (pick < 52) begin
        if (f3 == rvsec_pkg::F3_SLL || f3 == rvsec_pkg::F3_SR) w[31:25] = f7;
        issue(enc_i(w[31:20], w[19:15], f3, w[11:7], rvsec_pkg::OPC_OP_IMM));
      end else if (pick < 57) begin
        issue({w[31:7], rvsec_pkg::OPC_LUI});
      end else if (pick < 82) begin
        if ($urandom_range(4) == 0) w = $urandom;
        else w = win_base + $urandom_range(0, DMEM_BYTES + 4) - 3;
        if ($urandom_range(1)) mem_op(1'b1, $urandom_range(0, 2), w);
        else mem_op(1'b0, $urandom_range(0, 1) ? $urandom_range(0, 2)
                                                : $urandom_range(4, 5), w);
      end else if (pick < 89) begin
        issue(enc_b($urandom, $urandom_range(0, 3), $urandom_range(0, 3), f3));
      end else if (pick < 92) begin
        issue(enc_j($urandom, w[11:7]));
      end else if (pick < 95) begin
        issue(enc_i(w[31:20], w[19:15], ($urandom_range(3) == 0) ? f3 : 3'd0, w[11:7],
                    rvsec_pkg::OPC_JALR));
      end else begin
        issue(w);
      end
    end
  endtask

  initial begin
    instr_ch.valid = 1'b0;
    instr_ch.instr_word = '0;
    res_ch.ready = 1'b0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < DMEM_BYTES; i++) dmem[i] = '0;
    cur_pc = '0;
    win_base = {16'h0, rvsec_pkg::DATA_BASE_RESET};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_alu_extremes();
    test_mem_edges();
    test_control_flow();
    send_idle_pct = 16; recv_idle_pct = 69;
    cfg_write(16'hFFFF);
    test_mem_edges();
    test_random(185);
    send_idle_pct = 69; recv_idle_pct = 16;
    cfg_write(16'h0000);
    test_mem_edges();
    test_random(185);
    send_idle_pct = 0; recv_idle_pct = 0;
    cfg_write(16'($urandom));
    test_random(185);
    drain();
    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
